// ===== rtl/matrix_keypad_key_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad key tracker assertion macros
// Short forms for the concurrent checks used by the keypad tracker checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_KEY_TRACKER_DEFINES_SVH
`define MATRIX_KEYPAD_KEY_TRACKER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define MKKT_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("keypad tracker: same-cycle check failed");

// Property that must hold in the cycle after its trigger.
`define MKKT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("keypad tracker: next-cycle check failed");

`endif

// ===== rtl/mkkt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad key tracker package
// Shared constants, register indexes and the key phase type.
// ----------------------------------------------------------------------------
package mkkt_pkg;

   localparam int LIST_ENTRIES_DEF = 8;
   localparam int MAX_SIDE_DEF     = 4;
   localparam int MASK_STRIDE      = 4;

   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;

   localparam logic [15:0] DEBOUNCE_RESET_MS = 16'd10;
   localparam logic [15:0] HOLD_RESET_MS     = 16'd500;
   localparam logic [7:0]  NULL_KEY_CODE     = 8'h00;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYMAP_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYMAP_HIGH  = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_HOLD     = 2'd2,
      PH_RELEASED = 2'd3
   } phase_type;

endpackage

// ===== rtl/matrix_keypad_key_tracker.sv =====
// ----------------------------------------------------------------------------
// Matrix keypad key tracker
// Tracks pressed keys of a small matrix in a short list with hold detection.
// ----------------------------------------------------------------------------
// Each request on req_ carries one poll: a millisecond timestamp and the
// sampled pressed matrix. Every request yields exactly one response on rsp_.
// A poll that arrives within debounce_ms of the last processed poll is
// dropped and answered with an all-zero response.
// A processed poll passes through ST_CHECK for the debounce compare and
// idle-entry release, ST_WALK for the row-major walk, one key per step,
// and ST_FINISH to form and load the response. The walk step (list search,
// phase update) uses the shared elapsed-time subtractor. A dropped poll, or
// one with no rows or columns in use, goes from ST_CHECK to ST_FINISH. The
// block returns to ST_IDLE once the response is loaded and only then takes
// the next request, so it never takes a new poll before the last is done.
// req_tready is high only while no poll is in flight. A finished response
// sits in the output register while the next poll is accepted; if the
// receiver stalls, the next poll completes and waits until the register
// frees. Reset clears the list, both timestamps and the configuration to
// its defaults. csr_ writes are always taken and should be issued idle.
// ----------------------------------------------------------------------------
module matrix_keypad_key_tracker #(
   parameter int LIST_ENTRIES = mkkt_pkg::LIST_ENTRIES_DEF,
   parameter int MAX_SIDE     = mkkt_pkg::MAX_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // now_ms [31:0], pressed_mask [47:32]
   input  logic [mkkt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // key_valid [0], key_code [8:1], poll_accepted [9], change_seen [10]
   output logic [mkkt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mkkt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mkkt_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [2:0]  row_count_ff, column_count_ff;
   logic [15:0] debounce_ff, hold_ff;
   logic [63:0] keymap_low_ff, keymap_high_ff;

   // Poll being processed
   logic [31:0] now_ff;
   logic [15:0] mask_ff;
   logic        accepted_ff;
   logic [SIDE_W-1:0] row_ff, col_ff;

   // Timestamps
   logic [31:0] last_scan_ff, press_time_ff;

   // Entry list
   logic                   used_ff    [LIST_ENTRIES];
   logic                   changed_ff [LIST_ENTRIES];
   mkkt_pkg::phase_type    phase_ff   [LIST_ENTRIES];
   logic [3:0]             coord_ff   [LIST_ENTRIES];
   logic [7:0]             code_ff    [LIST_ENTRIES];

   // Output register
   logic                            rsp_valid_ff;
   logic [mkkt_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // Shared elapsed-time unit
   logic [31:0] base_time, elapsed;
   logic [15:0] limit;
   logic        over_limit;

   // Walk step
   logic [2:0]   rows_eff, cols_eff;
   logic [3:0]   key_idx, coord;
   logic [127:0] keymap_all;
   logic [7:0]   key_code;
   logic         closed;
   logic [LIST_ENTRIES-1:0] hit_oh, free_oh, sel_oh;
   logic         hit_any, free_any, take;
   mkkt_pkg::phase_type cur_phase, next_phase;
   logic         stamp, phase_chg;
   logic         last_col, last_row;

   // Response
   logic        any_chg, key_valid, change_seen, out_free;
   logic [7:0]  rsp_code;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rows_eff = (row_count_ff > 3'(MAX_SIDE)) ? 3'(MAX_SIDE) : row_count_ff;
   assign cols_eff = (column_count_ff > 3'(MAX_SIDE)) ? 3'(MAX_SIDE) : column_count_ff;

   // One subtract-and-compare serves the debounce test and the hold test.
   always_comb begin
      if (state_ff == ST_CHECK) begin
         base_time = last_scan_ff;
         limit     = debounce_ff;
      end else begin
         base_time = press_time_ff;
         limit     = hold_ff;
      end
      elapsed    = now_ff - base_time;
      over_limit = elapsed > {16'd0, limit};
   end

   assign key_idx    = 4'(row_ff) * 4'(mkkt_pkg::MASK_STRIDE) + 4'(col_ff);
   assign coord      = 4'(row_ff) * 4'(column_count_ff) + 4'(col_ff);
   assign keymap_all = {keymap_high_ff, keymap_low_ff};
   assign key_code   = keymap_all[{coord, 3'b000} +: 8];
   assign closed     = mask_ff[key_idx];

   always_comb begin
      hit_oh   = '0;
      free_oh  = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      for (int e = 0; e < LIST_ENTRIES; e++) begin
         if (!hit_any && used_ff[e] && (coord_ff[e] == coord)) begin
            hit_oh[e] = 1'b1;
            hit_any   = 1'b1;
         end
         if (!free_any && !used_ff[e]) begin
            free_oh[e] = 1'b1;
            free_any   = 1'b1;
         end
      end
   end

   assign take   = !hit_any && closed && free_any;
   assign sel_oh = hit_any ? hit_oh : (take ? free_oh : '0);

   always_comb begin
      cur_phase = mkkt_pkg::PH_IDLE;
      for (int e = 0; e < LIST_ENTRIES; e++) begin
         if (hit_oh[e]) begin
            cur_phase = phase_ff[e];
         end
      end
   end

   always_comb begin
      next_phase = cur_phase;
      unique case (cur_phase)
         mkkt_pkg::PH_IDLE: begin
            if (closed) next_phase = mkkt_pkg::PH_PRESSED;
         end
         mkkt_pkg::PH_PRESSED: begin
            if (over_limit) next_phase = mkkt_pkg::PH_HOLD;
            else if (!closed) next_phase = mkkt_pkg::PH_RELEASED;
         end
         mkkt_pkg::PH_HOLD: begin
            if (!closed) next_phase = mkkt_pkg::PH_RELEASED;
         end
         mkkt_pkg::PH_RELEASED: begin
            next_phase = mkkt_pkg::PH_IDLE;
         end
         default: begin
            next_phase = cur_phase;
         end
      endcase
   end

   assign phase_chg = (next_phase != cur_phase);
   assign stamp     = (hit_any || take) && closed && (cur_phase == mkkt_pkg::PH_IDLE);
   assign last_col  = (3'(col_ff) + 3'd1) == cols_eff;
   assign last_row  = (3'(row_ff) + 3'd1) == rows_eff;

   always_comb begin
      any_chg = 1'b0;
      for (int e = 0; e < LIST_ENTRIES; e++) begin
         any_chg = any_chg | changed_ff[e];
      end
   end

   assign key_valid    = accepted_ff && any_chg && used_ff[0] && changed_ff[0]
                         && (phase_ff[0] == mkkt_pkg::PH_PRESSED);
   assign change_seen  = accepted_ff && any_chg;
   assign rsp_code     = key_valid ? code_ff[0] : mkkt_pkg::NULL_KEY_CODE;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (over_limit && (rows_eff != 3'd0) && (cols_eff != 3'd0)) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            if (last_col && last_row) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration, timestamps and entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_count_ff    <= 3'd0;
         column_count_ff <= 3'd0;
         debounce_ff     <= mkkt_pkg::DEBOUNCE_RESET_MS;
         hold_ff         <= mkkt_pkg::HOLD_RESET_MS;
         keymap_low_ff   <= '0;
         keymap_high_ff  <= '0;
         accepted_ff     <= 1'b0;
         row_ff          <= '0;
         col_ff          <= '0;
         last_scan_ff    <= '0;
         press_time_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int e = 0; e < LIST_ENTRIES; e++) begin
            used_ff[e]    <= 1'b0;
            changed_ff[e] <= 1'b0;
            phase_ff[e]   <= mkkt_pkg::PH_IDLE;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            unique case (csr_index)
               mkkt_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_data[2:0];
               mkkt_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data[2:0];
               mkkt_pkg::CSR_DEBOUNCE_MS:  debounce_ff     <= csr_data[15:0];
               mkkt_pkg::CSR_HOLD_MS:      hold_ff         <= csr_data[15:0];
               mkkt_pkg::CSR_KEYMAP_LOW:   keymap_low_ff   <= csr_data;
               mkkt_pkg::CSR_KEYMAP_HIGH:  keymap_high_ff  <= csr_data;
               default: begin
               end
            endcase
         end

         if (state_ff == ST_CHECK) begin
            accepted_ff <= over_limit;
            row_ff      <= '0;
            col_ff      <= '0;
            if (over_limit) begin
               last_scan_ff <= now_ff;
               // Entries that have settled back to idle leave the list.
               for (int e = 0; e < LIST_ENTRIES; e++) begin
                  if (phase_ff[e] == mkkt_pkg::PH_IDLE) begin
                     used_ff[e]    <= 1'b0;
                     changed_ff[e] <= 1'b0;
                  end
               end
            end
         end

         if (state_ff == ST_WALK) begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= row_ff + SIDE_W'(1);
            end else begin
               col_ff <= col_ff + SIDE_W'(1);
            end
            if (stamp) press_time_ff <= now_ff;
            for (int e = 0; e < LIST_ENTRIES; e++) begin
               if (sel_oh[e]) begin
                  phase_ff[e]   <= next_phase;
                  changed_ff[e] <= phase_chg;
                  if (take) used_ff[e] <= 1'b1;
               end
            end
         end

         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff  <= req_tdata[31:0];
         mask_ff <= req_tdata[47:32];
      end
      if (state_ff == ST_WALK && take) begin
         for (int e = 0; e < LIST_ENTRIES; e++) begin
            if (free_oh[e]) begin
               coord_ff[e] <= coord;
               code_ff[e]  <= key_code;
            end
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= {5'd0, change_seen, accepted_ff, rsp_code, key_valid};
      end
   end

endmodule

// ===== rtl/mkkt_checker.sv =====
// ----------------------------------------------------------------------------
// Keypad key tracker checker
// Port-level checks on the request and response channels of the tracker.
// ----------------------------------------------------------------------------
`include "matrix_keypad_key_tracker_defines.svh"

module mkkt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mkkt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its contents.
   `MKKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The tracker works on one poll at a time.
   `MKKT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // A dropped poll reports nothing at all.
   `MKKT_ASSERT_SAME(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tdata[9], rsp_tdata == '0)

   // A new key implies a processed poll with a change in the list.
   `MKKT_ASSERT_SAME(a_key_implies, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[9] && rsp_tdata[10])

   // Without a new key the code reads as no key.
   `MKKT_ASSERT_SAME(a_code_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[8:1] == mkkt_pkg::NULL_KEY_CODE)

endmodule

bind matrix_keypad_key_tracker mkkt_checker u_mkkt_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad key tracker testbench
// Sends keypad polls through the request stream, predicts each response with
// a cycle-free model of the key list kept here, and compares every response
// field by field. Directed tests go first, then random key traffic under
// several geometries and timings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import mkkt_pkg::*;

   localparam int ENTRIES       = LIST_ENTRIES_DEF;
   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT   = 3000;

   typedef struct packed {
      logic       change_seen;
      logic       poll_accepted;
      logic [7:0] key_code;
      logic       key_valid;
   } poll_response_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Predicted register contents.
   logic [2:0]  cfg_rows        = 3'd0;
   logic [2:0]  cfg_cols        = 3'd0;
   logic [15:0] cfg_debounce    = DEBOUNCE_RESET_MS;
   logic [15:0] cfg_hold        = HOLD_RESET_MS;
   logic [63:0] cfg_keymap_low  = '0;
   logic [63:0] cfg_keymap_high = '0;

   // Predicted key list.
   logic        trk_used    [ENTRIES];
   logic [3:0]  trk_coord   [ENTRIES];
   logic [7:0]  trk_code    [ENTRIES];
   phase_type   trk_phase   [ENTRIES];
   logic        trk_changed [ENTRIES];
   logic [31:0] last_scan_ms   = '0;
   logic [31:0] press_stamp_ms = '0;

   poll_response_type poll_responses_due[$];
   int unsigned    mismatch_count = 0;

   logic [31:0] scan_clock_ms      = '0;
   logic [15:0] held_keys          = '0;
   logic        last_poll_accepted = 1'b0;
   bit          sender_idling      = 1'b0;
   bit          sink_stalling      = 1'b0;
   int unsigned rsp_hold_off       = 0;

   matrix_keypad_key_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Key list prediction
   // ---------------------------------------------------------------------
   function automatic void step_entry(input int e, input logic closed,
                                      input logic [31:0] now_ms);
      phase_type   nxt;
      logic [31:0] held_ms;
      nxt = trk_phase[e];
      held_ms = now_ms - press_stamp_ms;
      trk_changed[e] = 1'b0;
      case (trk_phase[e])
         PH_IDLE: begin
            if (closed) begin
               nxt = PH_PRESSED;
               press_stamp_ms = now_ms;
            end
         end
         PH_PRESSED: begin
            if (held_ms > {16'd0, cfg_hold}) nxt = PH_HOLD;
            else if (!closed) nxt = PH_RELEASED;
         end
         PH_HOLD: begin
            if (!closed) nxt = PH_RELEASED;
         end
         default: nxt = PH_IDLE;
      endcase
      // A released entry always counts as changed, even on its way to idle.
      if (nxt != trk_phase[e] || trk_phase[e] == PH_RELEASED) begin
         trk_phase[e]   = nxt;
         trk_changed[e] = 1'b1;
      end
   endfunction

   function automatic poll_response_type scan_poll(input logic [31:0] now_ms,
                                                   input logic [15:0] mask);
      poll_response_type res;
      logic [31:0]    since_last;
      logic [127:0]   keymap;
      int             rows, cols, r, c, e, hit, spot;
      logic           closed, any_change, fresh;
      res = '0;
      since_last = now_ms - last_scan_ms;
      if (since_last <= {16'd0, cfg_debounce}) return res;
      keymap = {cfg_keymap_high, cfg_keymap_low};
      rows = (cfg_rows > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cfg_rows;
      cols = (cfg_cols > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cfg_cols;
      for (e = 0; e < ENTRIES; e++) begin
         if (trk_phase[e] == PH_IDLE) begin
            trk_used[e]    = 1'b0;
            trk_changed[e] = 1'b0;
         end
      end
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            closed = mask[r * MASK_STRIDE + c];
            // The stride is the raw column count, so coordinates can wrap.
            spot = (r * int'(cfg_cols) + c) & 15;
            hit = -1;
            for (e = 0; e < ENTRIES && hit < 0; e++)
               if (trk_used[e] && trk_coord[e] == spot[3:0]) hit = e;
            if (hit >= 0) begin
               step_entry(hit, closed, now_ms);
            end else if (closed) begin
               for (e = 0; e < ENTRIES && hit < 0; e++) begin
                  if (!trk_used[e]) begin
                     hit = e;
                     trk_used[e]  = 1'b1;
                     trk_coord[e] = spot[3:0];
                     trk_code[e]  = keymap[spot * 8 +: 8];
                     trk_phase[e] = PH_IDLE;
                     step_entry(e, 1'b1, now_ms);
                  end
               end
            end
         end
      end
      any_change = 1'b0;
      for (e = 0; e < ENTRIES; e++) any_change = any_change | trk_changed[e];
      last_scan_ms = now_ms;
      fresh = any_change && trk_used[0] && trk_changed[0] && trk_phase[0] == PH_PRESSED;
      res.key_valid     = fresh;
      res.key_code      = fresh ? trk_code[0] : NULL_KEY_CODE;
      res.poll_accepted = 1'b1;
      res.change_seen   = any_change;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stream drivers
   // ---------------------------------------------------------------------
   function automatic int unsigned sender_gap();
      int unsigned pick;
      if (!sender_idling) return 0;
      pick = $urandom_range(0, 15);
      if (pick < 9) return 0;
      if (pick < 15) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_poll(input logic [31:0] now_ms, input logic [15:0] mask);
      int unsigned       gap;
      poll_response_type due;
      gap = sender_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mask, now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = scan_poll(now_ms, mask);
      poll_responses_due.push_back(due);
      last_poll_accepted = due.poll_accepted;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_ROW_COUNT:    cfg_rows        = value[2:0];
         CSR_COLUMN_COUNT: cfg_cols        = value[2:0];
         CSR_DEBOUNCE_MS:  cfg_debounce    = value[15:0];
         CSR_HOLD_MS:      cfg_hold        = value[15:0];
         CSR_KEYMAP_LOW:   cfg_keymap_low  = value;
         CSR_KEYMAP_HIGH:  cfg_keymap_high = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure_scan(input logic [2:0] rows, input logic [2:0] cols,
                                 input logic [15:0] debounce, input logic [15:0] hold,
                                 input logic [63:0] map_low, input logic [63:0] map_high);
      write_register(CSR_ROW_COUNT, {61'd0, rows});
      write_register(CSR_COLUMN_COUNT, {61'd0, cols});
      write_register(CSR_DEBOUNCE_MS, {48'd0, debounce});
      write_register(CSR_HOLD_MS, {48'd0, hold});
      write_register(CSR_KEYMAP_LOW, map_low);
      write_register(CSR_KEYMAP_HIGH, map_high);
   endtask

   // Registers may only change once the block has answered every poll.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (poll_responses_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly keys go down and up one at a time so that presses live long
   // enough to reach hold; now and then the whole matrix is replaced.
   task automatic run_random_phase(input int unsigned polls);
      int unsigned accepted_polls, pick;
      logic [31:0] noise;
      int          rows, cols, bit_pos;
      accepted_polls = 0;
      rows = (cfg_rows > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cfg_rows;
      cols = (cfg_cols > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cfg_cols;
      while (accepted_polls < polls) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) scan_clock_ms = scan_clock_ms + $urandom_range(0, cfg_debounce);
         else if (pick == 1) scan_clock_ms = scan_clock_ms + $urandom;
         else scan_clock_ms = scan_clock_ms + cfg_debounce + 1 + $urandom_range(0, 30);
         pick = $urandom_range(0, 19);
         noise = $urandom;
         if (pick == 0) begin
            held_keys = noise[15:0];
         end else if (pick == 1) begin
            held_keys = '0;
         end else if (pick == 2) begin
            held_keys[noise[3:0]] = ~held_keys[noise[3:0]];
         end else if (pick < 10 && rows != 0 && cols != 0) begin
            bit_pos = $urandom_range(0, rows - 1) * MASK_STRIDE + $urandom_range(0, cols - 1);
            held_keys[bit_pos] = ~held_keys[bit_pos];
         end
         send_poll(scan_clock_ms, held_keys);
         if (last_poll_accepted) accepted_polls++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------
   initial begin : response_sink
      int unsigned low_cycles;
      forever begin
         @(posedge clock);
         low_cycles = 0;
         if (rsp_hold_off != 0) begin
            low_cycles = rsp_hold_off;
            rsp_hold_off = 0;
         end else if (sink_stalling && $urandom_range(0, 3) == 0) begin
            low_cycles = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(1, 3);
         end
         if (low_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (low_cycles - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : response_check
      poll_response_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (poll_responses_due.size() == 0) begin
            report_mismatch("response with no poll pending", {16'd0, rsp_tdata}, 32'd0);
         end else begin
            due = poll_responses_due.pop_front();
            if (rsp_tdata[0] !== due.key_valid)
               report_mismatch("key_valid", {31'd0, rsp_tdata[0]}, {31'd0, due.key_valid});
            if (rsp_tdata[8:1] !== due.key_code)
               report_mismatch("key_code", {24'd0, rsp_tdata[8:1]}, {24'd0, due.key_code});
            if (rsp_tdata[9] !== due.poll_accepted)
               report_mismatch("poll_accepted", {31'd0, rsp_tdata[9]},
                               {31'd0, due.poll_accepted});
            if (rsp_tdata[10] !== due.change_seen)
               report_mismatch("change_seen", {31'd0, rsp_tdata[10]},
                               {31'd0, due.change_seen});
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Default geometry walks nothing; the first poll lands exactly on the
   // debounce limit and is dropped.
   task automatic test_reset_state();
      send_poll(32'd10, 16'hFFFF);
      send_poll(32'd11, 16'hFFFF);
      send_poll(32'hFFFF_FFFF, 16'h0000);
      drain_responses();
   endtask

   // All sixteen keys at once: eight are tracked, the rest find no entry.
   // Coordinate zero carries code zero, so the first press reports code 0.
   task automatic test_list_overflow();
      configure_scan(3'd4, 3'd4, 16'd0, 16'hFFFF, {$urandom, $urandom} & ~64'hFF,
                     64'hFFFF_FFFF_FFFF_FFFF);
      send_poll(32'd5, 16'hFFFF);
      send_poll(32'd6, 16'h0000);
      send_poll(32'd6, 16'h0000);
      send_poll(32'd7, 16'h0000);
      send_poll(32'd8, 16'hFF00);
      drain_responses();
   endtask

   task automatic test_hold_detection();
      write_register(CSR_HOLD_MS, 64'd0);
      send_poll(32'd20, 16'h0001);
      send_poll(32'd21, 16'h0000);
      send_poll(32'd22, 16'h0000);
      send_poll(32'd23, 16'h0000);
      drain_responses();
   endtask

   // A tracked key outside a shrunken walk keeps its phase and changed bit.
   // Oversized counts clamp the walk but keep the raw coordinate stride.
   task automatic test_geometry_change();
      write_register(CSR_HOLD_MS, 64'hFFFF);
      send_poll(32'd30, 16'h8000);
      drain_responses();
      write_register(CSR_ROW_COUNT, 64'd2);
      write_register(CSR_COLUMN_COUNT, 64'd2);
      send_poll(32'd40, 16'h0011);
      drain_responses();
      write_register(CSR_ROW_COUNT, 64'd7);
      write_register(CSR_COLUMN_COUNT, 64'd7);
      send_poll(32'd50, 16'hFFFF);
      drain_responses();
   endtask

   task automatic test_debounce_limits();
      write_register(CSR_DEBOUNCE_MS, 64'hFFFF);
      send_poll(32'd50 + 32'd65535, 16'h0001);
      send_poll(32'd50 + 32'd65536, 16'h0001);
      send_poll(32'd0, 16'h0000);
      drain_responses();
      scan_clock_ms = 32'd0;
   endtask

   task automatic test_random_traffic();
      sender_idling = 1'b1;
      sink_stalling = 1'b1;
      configure_scan(3'd4, 3'd4, 16'd10, 16'd50, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_phase(350);
      drain_responses();

      sender_idling = 1'b0;
      sink_stalling = 1'b0;
      configure_scan(3'd3, 3'd2, 16'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
      run_random_phase(200);
      drain_responses();

      sender_idling = 1'b1;
      configure_scan(3'd7, 3'd7, 16'd5, 16'd80, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_phase(250);
      drain_responses();

      sender_idling = 1'b0;
      sink_stalling = 1'b1;
      configure_scan(3'd2, 3'd4, 16'hFFFF, 16'hFFFF, 64'd0, 64'd0);
      run_random_phase(150);
      drain_responses();

      // Run the millisecond counter across its wrap.
      sender_idling = 1'b1;
      scan_clock_ms = 32'hFFFF_FF00;
      configure_scan(3'd4, 3'd1, 16'd3, 16'd20, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_phase(200);
      drain_responses();

      scan_clock_ms = $urandom;
      configure_scan(3'd0, 3'd3, 16'd10, 16'd40, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_phase(30);
      drain_responses();
   endtask

   // The sink refuses responses for a long stretch while requests keep
   // coming, so the tracker fills up and holds off its request side.
   task automatic test_output_backpressure();
      sender_idling = 1'b1;
      sink_stalling = 1'b1;
      configure_scan(3'd4, 3'd3, 16'd1, 16'd100, {$urandom, $urandom}, {$urandom, $urandom});
      run_random_phase(80);
      rsp_hold_off = 300;
      run_random_phase(170);
      drain_responses();
   endtask

   initial begin : main_sequence
      int e;
      for (e = 0; e < ENTRIES; e++) begin
         trk_used[e]    = 1'b0;
         trk_coord[e]   = '0;
         trk_code[e]    = '0;
         trk_phase[e]   = PH_IDLE;
         trk_changed[e] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_list_overflow();
      test_hold_detection();
      test_geometry_change();
      test_debounce_limits();
      test_random_traffic();
      test_output_backpressure();

      if (mismatch_count == 0 && poll_responses_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
